/* sv/vcm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vcm_pkg
// Shared types, register indexes and elaboration-time helpers for the
// value-to-colour map.
// ----------------------------------------------------------------------------
package vcm_pkg;

    // One input item: a sample to map, or a palette entry to write
    typedef struct packed {
        logic               action;
        logic signed [31:0] sample_value;
        logic [3:0]         entry_index;
        logic [7:0]         entry_red;
        logic [7:0]         entry_green;
        logic [7:0]         entry_blue;
        logic [7:0]         entry_opacity;
    } vcm_in_t;

    // One result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } vcm_out_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_RANGE_MIN     = 3'd0,
        CFG_RANGE_MAX     = 3'd1,
        CFG_CENTRE_VALUE  = 3'd2,
        CFG_LOG_MODE      = 3'd3,
        CFG_CENTRED_MODE  = 3'd4,
        CFG_DISCRETE_MODE = 3'd5,
        CFG_PALETTE_SIZE  = 3'd6
    } cfg_index_t;

    // Palette write info carried down the pipe; rgba holds red in 7:0
    typedef struct packed {
        logic        action;
        logic [3:0]  entry_index;
        logic [31:0] rgba;
    } wr_item_t;

    // Divider stage state
    typedef struct packed {
        logic [48:0] rem;
        logic [32:0] dvs;
        logic [15:0] quo;
        logic        neg;
        logic        base_half;
        logic        lo;
        logic        hi;
    } div_t;

    // Position of the leading one of a positive 31-bit value
    function automatic logic [4:0] msb_pos(input logic [30:0] x);
        logic [4:0] p;
        p = '0;
        for (int b = 0; b < 31; b++) begin
            if (x[b]) begin
                p = 5'(b);
            end
        end
        return p;
    endfunction

    // log2 of a Q2.30 mantissa in [1,2), 16 fraction bits, by repeated squaring
    function automatic logic [15:0] log_frac_calc(input longint unsigned m0);
        longint unsigned m;
        logic [15:0]     r;
        m = m0;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            r = {r[14:0], 1'b0};
            if (m >= (64'd2 << 30)) begin
                m    = m >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/vcm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vcm_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module vcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  raddr_a,
    input  wire [$clog2(DEPTH)-1:0]  raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads, held while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

/* sv/value_to_colour_map.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// value_to_colour_map
// Maps a signed Q16.16 sample to an RGBA colour through a palette.
// ----------------------------------------------------------------------------
// The block takes one item per clock when the result side does not stall.
// A 27-stage pipe does the work: leading-one search and log table lookup,
// scaling operand select, a 16-stage restoring divider (one quotient bit per
// stage), scale result, palette address, a registered palette read and the
// blend. Palette writes travel down the same pipe and land at the palette
// read stage, so a write affects every sample taken after it and none before.
// Entries never written read back as unknown. Configuration registers are
// to be written by the user through the cfg port only while no item is in
// flight; the block itself does not enforce this.
module value_to_colour_map
    import vcm_pkg::*;
#(
    parameter int PALETTE_DEPTH   = 16,
    parameter int LOG_TABLE_DEPTH = 64
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire vcm_in_t s_data,
    output logic         m_valid,
    input  wire          m_ready,
    output vcm_out_t     m_data,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [2:0]    cfg_index,
    input  wire [31:0]   cfg_data
);

    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int LT_IW   = $clog2(LOG_TABLE_DEPTH);
    localparam int ST_DIV0 = 7;
    localparam int ST_SCL  = ST_DIV0 + 16;
    localparam int ST_ADR  = ST_SCL + 1;
    localparam int ST_RD   = ST_ADR + 1;
    localparam int ST_OUT  = ST_RD + 1;
    localparam int NST     = ST_OUT + 1;

    // sign-extending 33-bit difference
    function automatic logic signed [32:0] sub33(input logic [31:0] a,
                                                 input logic [31:0] b);
        return $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    // argument of the log: values at or below zero count as one LSB
    function automatic logic [30:0] log_arg(input logic [31:0] v);
        return (!v[31] && (|v[30:0])) ? v[30:0] : 31'd1;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] cfg_min_reg;
    logic signed [31:0] cfg_max_reg;
    logic signed [31:0] cfg_ctr_reg;
    logic               cfg_log_reg;
    logic               cfg_cen_reg;
    logic               cfg_dsc_reg;
    logic [4:0]         cfg_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_min_reg  <= 32'sd0;
            cfg_max_reg  <= 32'sd65536;
            cfg_ctr_reg  <= 32'sd32768;
            cfg_log_reg  <= 1'b0;
            cfg_cen_reg  <= 1'b0;
            cfg_dsc_reg  <= 1'b0;
            cfg_size_reg <= 5'd3;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_RANGE_MIN:     cfg_min_reg  <= cfg_data;
                CFG_RANGE_MAX:     cfg_max_reg  <= cfg_data;
                CFG_CENTRE_VALUE:  cfg_ctr_reg  <= cfg_data;
                CFG_LOG_MODE:      cfg_log_reg  <= cfg_data[0];
                CFG_CENTRED_MODE:  cfg_cen_reg  <= cfg_data[0];
                CFG_DISCRETE_MODE: cfg_dsc_reg  <= cfg_data[0];
                CFG_PALETTE_SIZE:  cfg_size_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Log fraction table, built at elaboration
    // ------------------------------------------------------------------
    logic [15:0] log_tbl [LOG_TABLE_DEPTH];

    for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_log_tbl
        localparam longint unsigned M0 =
            (64'd1 << 30) + ((64'(gi) << 30) / LOG_TABLE_DEPTH);
        assign log_tbl[gi] = log_frac_calc(M0);
    end

    // ------------------------------------------------------------------
    // Stage valids and load enables; a stage loads when empty or moving
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] ld;
    wr_item_t       adr_wr_reg;

    always_comb begin
        ld[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    always_comb begin
        vld_next[0] = s_valid;
        for (int k = 1; k < NST; k++) begin
            vld_next[k] = vld_reg[k-1];
        end
        // palette writes leave the pipe at the read stage
        vld_next[ST_RD] = vld_reg[ST_ADR] && !adr_wr_reg.action;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (ld[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_ready = ld[0];
    assign m_valid = vld_reg[NST-1];

    // ------------------------------------------------------------------
    // Stage 0: leading-one search for sample, min and max
    // ------------------------------------------------------------------
    wr_item_t           s0_wr_reg;
    logic signed [31:0] s0_smp_reg;
    logic [30:0]        s0_x_reg [3];
    logic [4:0]         s0_p_reg [3];
    logic signed [32:0] s0_dmm_reg;
    logic [30:0]        s0_x [3];

    assign s0_x[0] = log_arg(s_data.sample_value);
    assign s0_x[1] = log_arg(cfg_min_reg);
    assign s0_x[2] = log_arg(cfg_max_reg);

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            s0_wr_reg  <= '{action: s_data.action, entry_index: s_data.entry_index,
                           rgba: {s_data.entry_opacity, s_data.entry_blue,
                                  s_data.entry_green, s_data.entry_red}};
            s0_smp_reg <= s_data.sample_value;
            s0_dmm_reg <= sub33(cfg_max_reg, cfg_min_reg);
            for (int i = 0; i < 3; i++) begin
                s0_x_reg[i] <= s0_x[i];
                s0_p_reg[i] <= msb_pos(s0_x[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: normalize, half range
    // ------------------------------------------------------------------
    wr_item_t           s1_wr_reg;
    logic signed [31:0] s1_smp_reg;
    logic [29:0]        s1_frac_reg [3];
    logic [4:0]         s1_p_reg [3];
    logic signed [31:0] s1_half_reg;
    logic [32:0]        s1_hsum;

    assign s1_hsum = s0_dmm_reg + {32'd0, s0_dmm_reg[32]};

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            s1_wr_reg   <= s0_wr_reg;
            s1_smp_reg  <= s0_smp_reg;
            s1_half_reg <= s1_hsum[32:1];
            for (int i = 0; i < 3; i++) begin
                s1_frac_reg[i] <= 30'(s0_x_reg[i] << (5'd30 - s0_p_reg[i]));
                s1_p_reg[i]    <= s0_p_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: log table index, effective centre
    // ------------------------------------------------------------------
    wr_item_t           s2_wr_reg;
    logic signed [31:0] s2_smp_reg;
    logic [LT_IW-1:0]   s2_idx_reg [3];
    logic [4:0]         s2_p_reg [3];
    logic signed [31:0] s2_ctr_reg;
    logic [30+LT_IW:0]  s2_prod [3];
    logic [LT_IW:0]     s2_ix [3];
    logic signed [31:0] s2_mid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_prod[i] = (31+LT_IW)'(s1_frac_reg[i]) * (31+LT_IW)'(LOG_TABLE_DEPTH);
            s2_ix[i]   = s2_prod[i][30+LT_IW:30];
            if (s2_ix[i] >= (LT_IW+1)'(LOG_TABLE_DEPTH)) begin
                s2_ix[i] = (LT_IW+1)'(LOG_TABLE_DEPTH - 1);
            end
        end
        s2_mid = cfg_min_reg + s1_half_reg;
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            s2_wr_reg  <= s1_wr_reg;
            s2_smp_reg <= s1_smp_reg;
            s2_ctr_reg <= (cfg_ctr_reg == cfg_min_reg || cfg_ctr_reg == cfg_max_reg)
                          ? s2_mid : cfg_ctr_reg;
            for (int i = 0; i < 3; i++) begin
                s2_idx_reg[i] <= LT_IW'(s2_ix[i]);
                s2_p_reg[i]   <= s1_p_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: log values, centred operands
    // ------------------------------------------------------------------
    wr_item_t           s3_wr_reg;
    logic signed [31:0] s3_smp_reg;
    logic signed [21:0] s3_lg_reg [3];
    logic signed [32:0] s3_numc_reg;
    logic signed [32:0] s3_denc_reg;
    logic               s3_gt_reg;
    logic               s3_gt;

    assign s3_gt = s2_smp_reg > s2_ctr_reg;

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            s3_wr_reg   <= s2_wr_reg;
            s3_smp_reg  <= s2_smp_reg;
            s3_gt_reg   <= s3_gt;
            s3_numc_reg <= s3_gt ? sub33(s2_smp_reg, s2_ctr_reg)
                                 : sub33(s2_smp_reg, cfg_min_reg);
            s3_denc_reg <= s3_gt ? sub33(cfg_max_reg, s2_ctr_reg)
                                 : sub33(s2_ctr_reg, cfg_min_reg);
            for (int i = 0; i < 3; i++) begin
                s3_lg_reg[i] <= {6'({1'b0, s2_p_reg[i]}) - 6'd16, log_tbl[s2_idx_reg[i]]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick numerator, denominator and base by mode
    // ------------------------------------------------------------------
    wr_item_t           s4_wr_reg;
    logic signed [32:0] s4_num_reg;
    logic signed [32:0] s4_den_reg;
    logic               s4_base_reg;
    logic               s4_cen_reg;
    logic               s4_elo_reg;
    logic signed [32:0] s4_lg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s4_lg[i] = {{11{s3_lg_reg[i][21]}}, s3_lg_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            s4_wr_reg <= s3_wr_reg;
            if (cfg_log_reg) begin
                s4_num_reg  <= s4_lg[0] - s4_lg[1];
                s4_den_reg  <= s4_lg[2] - s4_lg[1];
                s4_base_reg <= 1'b0;
                s4_cen_reg  <= 1'b0;
                s4_elo_reg  <= s3_smp_reg[31] || !(|s3_smp_reg[30:0]);
            end else if (cfg_cen_reg) begin
                s4_num_reg  <= s3_numc_reg;
                s4_den_reg  <= s3_denc_reg;
                s4_base_reg <= s3_gt_reg;
                s4_cen_reg  <= 1'b1;
                s4_elo_reg  <= 1'b0;
            end else begin
                s4_num_reg  <= sub33(s3_smp_reg, cfg_min_reg);
                s4_den_reg  <= sub33(cfg_max_reg, cfg_min_reg);
                s4_base_reg <= 1'b0;
                s4_cen_reg  <= 1'b0;
                s4_elo_reg  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: magnitudes and quotient sign
    // ------------------------------------------------------------------
    wr_item_t    s5_wr_reg;
    logic [32:0] s5_mnum_reg;
    logic [32:0] s5_mden_reg;
    logic        s5_nz_reg;
    logic        s5_neg_reg;
    logic        s5_base_reg;
    logic        s5_cen_reg;
    logic        s5_elo_reg;

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            s5_wr_reg   <= s4_wr_reg;
            s5_mnum_reg <= s4_num_reg[32] ? 33'(-s4_num_reg) : 33'(s4_num_reg);
            s5_mden_reg <= s4_den_reg[32] ? 33'(-s4_den_reg) : 33'(s4_den_reg);
            s5_nz_reg   <= |s4_num_reg;
            s5_neg_reg  <= (|s4_num_reg) && (s4_num_reg[32] ^ s4_den_reg[32]);
            s5_base_reg <= s4_base_reg;
            s5_cen_reg  <= s4_cen_reg;
            s5_elo_reg  <= s4_elo_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: saturation check, divider setup
    // ------------------------------------------------------------------
    wr_item_t s6_wr_reg;
    div_t     s6_div_reg;
    logic     s6_sat;

    // clamp limit: |num| >= |den|, or |num| >= 2|den| below a split centre
    assign s6_sat = s5_nz_reg &&
                    ((s5_cen_reg && !s5_base_reg)
                     ? ({1'b0, s5_mnum_reg} >= {s5_mden_reg, 1'b0})
                     : (s5_mnum_reg >= s5_mden_reg));

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            s6_wr_reg            <= s5_wr_reg;
            s6_div_reg.rem       <= s5_cen_reg ? {1'b0, s5_mnum_reg, 15'd0}
                                               : {s5_mnum_reg, 16'd0};
            s6_div_reg.dvs       <= s5_mden_reg;
            s6_div_reg.quo       <= '0;
            s6_div_reg.neg       <= s5_neg_reg;
            s6_div_reg.base_half <= s5_base_reg;
            // a zero numerator gives s = 0, also over a zero divisor
            s6_div_reg.lo        <= s5_elo_reg || !s5_nz_reg || (s6_sat && s5_neg_reg);
            s6_div_reg.hi        <= !s5_elo_reg && s6_sat && !s5_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, MSB first
    // ------------------------------------------------------------------
    div_t     dv_reg  [16];
    div_t     dv_in   [16];
    div_t     dv_next [16];
    wr_item_t dvw_reg [16];
    wr_item_t dvw_in  [16];

    for (genvar gj = 0; gj < 16; gj++) begin : g_div
        localparam int BIT = 15 - gj;
        logic [48:0] dsh;

        if (gj == 0) begin : g_first
            assign dv_in[gj]  = s6_div_reg;
            assign dvw_in[gj] = s6_wr_reg;
        end else begin : g_next
            assign dv_in[gj]  = dv_reg[gj-1];
            assign dvw_in[gj] = dvw_reg[gj-1];
        end

        assign dsh = {16'd0, dv_in[gj].dvs} << BIT;

        always_comb begin
            dv_next[gj] = dv_in[gj];
            if (dv_in[gj].rem >= dsh) begin
                dv_next[gj].rem      = dv_in[gj].rem - dsh;
                dv_next[gj].quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (ld[ST_DIV0+gj]) begin
                dv_reg[gj]  <= dv_next[gj];
                dvw_reg[gj] <= dvw_in[gj];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale result: fraction s in Q0.16, or clamped low / high
    // ------------------------------------------------------------------
    wr_item_t    scl_wr_reg;
    logic [15:0] scl_s_reg;
    logic        scl_lo_reg;
    logic        scl_hi_reg;
    logic [16:0] scl_base;
    logic [16:0] scl_q;
    logic [16:0] scl_s;
    logic        scl_lo;
    logic        scl_hi;

    always_comb begin
        scl_base = dv_reg[15].base_half ? 17'h08000 : 17'h00000;
        scl_q    = {1'b0, dv_reg[15].quo};
        scl_s    = '0;
        scl_lo   = 1'b0;
        scl_hi   = 1'b0;
        if (dv_reg[15].lo) begin
            scl_lo = 1'b1;
        end else if (dv_reg[15].hi) begin
            scl_hi = 1'b1;
        end else if (dv_reg[15].neg) begin
            if (scl_q >= scl_base) begin
                scl_lo = 1'b1;
            end else begin
                scl_s = scl_base - scl_q;
            end
        end else begin
            scl_s  = scl_base + scl_q;
            scl_lo = (scl_s == 17'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_SCL]) begin
            scl_wr_reg <= dvw_reg[15];
            scl_s_reg  <= scl_s[15:0];
            scl_lo_reg <= scl_lo;
            scl_hi_reg <= scl_hi;
        end
    end

    // ------------------------------------------------------------------
    // Palette addresses and blend weight
    // ------------------------------------------------------------------
    logic [PAL_AW-1:0] adr_a_reg;
    logic [PAL_AW-1:0] adr_b_reg;
    logic [15:0]       adr_r_reg;
    logic [4:0]        adr_n;
    logic [20:0]       adr_pos;
    logic [20:0]       adr_band;
    logic [4:0]        adr_a;
    logic [4:0]        adr_b;
    logic [15:0]       adr_r;

    always_comb begin
        if (cfg_size_reg == 5'd0) begin
            adr_n = 5'd1;
        end else if ({4'd0, cfg_size_reg} > 9'(PALETTE_DEPTH)) begin
            adr_n = 5'(PALETTE_DEPTH);
        end else begin
            adr_n = cfg_size_reg;
        end
        adr_pos  = 21'(adr_n - 5'd1) * 21'(scl_s_reg);
        adr_band = 21'(adr_n) * 21'(scl_s_reg);
        adr_a    = 5'd0;
        adr_b    = 5'd0;
        adr_r    = 16'd0;
        if (scl_lo_reg || adr_n == 5'd1) begin
            adr_a = 5'd0;
            adr_b = 5'd0;
        end else if (scl_hi_reg) begin
            adr_a = adr_n - 5'd1;
            adr_b = adr_n - 5'd1;
        end else if (!cfg_dsc_reg) begin
            adr_a = adr_pos[20:16];
            adr_b = adr_pos[20:16] + 5'd1;
            adr_r = adr_pos[15:0];
        end else begin
            adr_a = (adr_band[20:16] >= adr_n) ? adr_n - 5'd1 : adr_band[20:16];
            adr_b = adr_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_ADR]) begin
            adr_wr_reg <= scl_wr_reg;
            adr_a_reg  <= PAL_AW'(adr_a);
            adr_b_reg  <= PAL_AW'(adr_b);
            adr_r_reg  <= adr_r;
        end
    end

    // ------------------------------------------------------------------
    // Palette memory; writes and reads both happen on leaving ST_ADR
    // ------------------------------------------------------------------
    logic        pal_we;
    logic [31:0] pal_a;
    logic [31:0] pal_b;
    logic [15:0] rd_r_reg;

    assign pal_we = ld[ST_RD] && vld_reg[ST_ADR] && adr_wr_reg.action &&
                    ({5'd0, adr_wr_reg.entry_index} < 9'(PALETTE_DEPTH));

    vcm_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .we      (pal_we),
        .waddr   (PAL_AW'(adr_wr_reg.entry_index)),
        .wdata   (adr_wr_reg.rgba),
        .rd_en   (ld[ST_RD]),
        .raddr_a (adr_a_reg),
        .raddr_b (adr_b_reg),
        .rdata_a (pal_a),
        .rdata_b (pal_b)
    );

    always_ff @(posedge aclk) begin
        if (ld[ST_RD]) begin
            rd_r_reg <= adr_r_reg;
        end
    end

    // ------------------------------------------------------------------
    // Blend neighbors and register the result
    // ------------------------------------------------------------------
    vcm_out_t    out_reg;
    logic [31:0] out_rgba;
    logic [24:0] out_acc [4];
    logic [16:0] out_wa;

    always_comb begin
        out_wa = 17'h10000 - 17'(rd_r_reg);
        for (int k = 0; k < 4; k++) begin
            out_acc[k] = 25'(pal_a[8*k +: 8]) * 25'(out_wa) +
                         25'(pal_b[8*k +: 8]) * 25'(rd_r_reg) + 25'd32768;
            out_rgba[8*k +: 8] = out_acc[k][23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[ST_OUT]) begin
            out_reg.red     <= out_rgba[7:0];
            out_reg.green   <= out_rgba[15:8];
            out_reg.blue    <= out_rgba[23:16];
            out_reg.opacity <= (cfg_max_reg == cfg_min_reg) ? 8'd0 : out_rgba[31:24];
        end
    end

    assign m_data = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output side is free");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_SCL-1] && !dv_reg[15].lo && !dv_reg[15].hi && (|dv_reg[15].dvs))
        |-> (dv_reg[15].rem < 49'(dv_reg[15].dvs)))
        else $error("divider remainder not below divisor");

    a_addr_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_ADR] && !adr_wr_reg.action)
        |-> (adr_b_reg == adr_a_reg || adr_b_reg == adr_a_reg + PAL_AW'(1)))
        else $error("palette read addresses are not neighbors");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_ADR] && adr_wr_reg.action && ld[ST_RD]) |=> !vld_reg[ST_RD])
        else $error("palette write produced a result");

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value-to-colour map testbench
// Loads the palette, then maps directed and random samples through linear,
// centred, logarithmic and discrete scaling. It also covers degenerate,
// reversed and empty ranges and varied palette sizes. Each colour is checked
// against a scoreboard fed by a predictor that runs in transfer order.
// ----------------------------------------------------------------------------
module testbench;
    import vcm_pkg::*;

    localparam int DEPTH     = 16;
    localparam int LOG_DEPTH = 64;
    localparam int DRAIN     = 40;
    localparam longint SAT   = 64'sd1 << 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    vcm_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    vcm_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Predictor state: palette, log table and register copies
    logic [31:0] pal_model [DEPTH];
    longint      log_tbl [LOG_DEPTH];
    longint      lim_lo, lim_hi, mid_pt;
    bit          log_on, split_on, band_on;
    int          n_entries;

    vcm_out_t    colour_q [$];
    int          errors = 0;
    int          n_samples = 0;
    int          n_writes = 0;
    int          n_checked = 0;
    bit          sender_calm = 1'b0;
    bit          sink_calm = 1'b0;

    value_to_colour_map DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // Log fraction table by repeated squaring of the Q2.30 mantissa
    initial begin
        longint unsigned m;
        longint          r;
        for (int i = 0; i < LOG_DEPTH; i++) begin
            m = (64'd1 << 30) + ((64'(i) << 30) / LOG_DEPTH);
            r = 0;
            for (int k = 0; k < 16; k++) begin
                m = (m * m) >> 30;
                r = r << 1;
                if (m >= (64'd2 << 30)) begin
                    m = m >> 1;
                    r = r | 1;
                end
            end
            log_tbl[i] = r;
        end
    end

    function automatic longint sx32(input logic [31:0] u);
        return longint'(signed'(u));
    endfunction

    function automatic longint ratio(input longint num, input longint mul,
                                     input longint den);
        if (den == 0) begin
            return num > 0 ? SAT : (num < 0 ? -SAT : 0);
        end
        return (num * mul) / den;
    endfunction

    function automatic longint log2_q16(input longint x);
        longint unsigned ux, idx;
        int p;
        if (x <= 0) begin
            x = 1;
        end
        ux = x;
        p = 0;
        for (int b = 0; b < 32; b++) begin
            if (ux[b]) begin
                p = b;
            end
        end
        idx = ((ux - (64'd1 << p)) * LOG_DEPTH) >> p;
        if (idx >= LOG_DEPTH) begin
            idx = LOG_DEPTH - 1;
        end
        return longint'(p - 16) * 65536 + log_tbl[idx];
    endfunction

    // Fraction of the range in Q0.16, not clamped
    function automatic longint range_fraction(input longint v);
        longint c;
        if (log_on) begin
            if (v <= 0) begin
                return 0;
            end
            return ratio(log2_q16(v) - log2_q16(lim_lo), 65536,
                         log2_q16(lim_hi) - log2_q16(lim_lo));
        end
        if (!split_on) begin
            return ratio(v - lim_lo, 65536, lim_hi - lim_lo);
        end
        c = mid_pt;
        if (c == lim_lo || c == lim_hi) begin
            c = lim_lo + (lim_hi - lim_lo) / 2;
        end
        if (v > c) begin
            return 32768 + ratio(v - c, 32768, lim_hi - c);
        end
        return ratio(v - lim_lo, 32768, c - lim_lo);
    endfunction

    function automatic vcm_out_t to_colour(input logic [31:0] w);
        vcm_out_t o;
        o.red     = w[7:0];
        o.green   = w[15:8];
        o.blue    = w[23:16];
        o.opacity = w[31:24];
        return o;
    endfunction

    function automatic vcm_out_t map_colour(input logic [31:0] sample);
        longint unsigned n, pos, lo, r, idx, a, b;
        longint s;
        logic [31:0] w;
        n = (n_entries == 0) ? 1 : (n_entries > DEPTH ? DEPTH : n_entries);
        s = range_fraction(sx32(sample));
        if (s <= 0 || n == 1) begin
            w = pal_model[0];
        end else if (s >= 65536) begin
            w = pal_model[n - 1];
        end else if (!band_on) begin
            pos = (n - 1) * longint'(s);
            lo  = pos >> 16;
            r   = pos & 16'hFFFF;
            for (int k = 0; k < 4; k++) begin
                a = pal_model[lo][8*k +: 8];
                b = pal_model[lo + 1][8*k +: 8];
                w[8*k +: 8] = 8'((a * (65536 - r) + b * r + 32768) >> 16);
            end
        end else begin
            idx = (n * longint'(s)) >> 16;
            if (idx >= n) begin
                idx = n - 1;
            end
            w = pal_model[idx];
        end
        if (lim_hi == lim_lo) begin
            w[31:24] = 8'd0;
        end
        return to_colour(w);
    endfunction

    // Apply one accepted item to the predictor
    task automatic predict(input vcm_in_t item);
        if (item.action) begin
            pal_model[item.entry_index] = {item.entry_opacity, item.entry_blue,
                                           item.entry_green, item.entry_red};
            n_writes++;
        end else begin
            colour_q.push_back(map_colour(item.sample_value));
            n_samples++;
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // One input transfer; valid stays up if the next item has no gap
    task automatic send_item(input vcm_in_t item);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict(item);
    endtask

    task automatic send_sample(input logic [31:0] v);
        vcm_in_t item;
        item = vcm_in_t'({$urandom, $urandom});
        item.action = 1'b0;
        item.sample_value = v;
        send_item(item);
    endtask

    task automatic send_entry(input logic [3:0] idx, input logic [31:0] rgba);
        vcm_in_t item;
        item = vcm_in_t'({$urandom, $urandom});
        item.action        = 1'b1;
        item.entry_index   = idx;
        item.entry_red     = rgba[7:0];
        item.entry_green   = rgba[15:8];
        item.entry_blue    = rgba[23:16];
        item.entry_opacity = rgba[31:24];
        send_item(item);
    endtask

    // Hold off until all colours are back and in-flight writes have landed
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (colour_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RANGE_MIN:     lim_lo    = sx32(val);
            CFG_RANGE_MAX:     lim_hi    = sx32(val);
            CFG_CENTRE_VALUE:  mid_pt    = sx32(val);
            CFG_LOG_MODE:      log_on    = val[0];
            CFG_CENTRED_MODE:  split_on  = val[0];
            CFG_DISCRETE_MODE: band_on   = val[0];
            CFG_PALETTE_SIZE:  n_entries = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] ctr, input bit lg, input bit cen,
                            input bit disc, input logic [4:0] size);
        wait_drained();
        write_reg(CFG_RANGE_MIN, lo);
        write_reg(CFG_RANGE_MAX, hi);
        write_reg(CFG_CENTRE_VALUE, ctr);
        write_reg(CFG_LOG_MODE, 32'(lg));
        write_reg(CFG_CENTRED_MODE, 32'(cen));
        write_reg(CFG_DISCRETE_MODE, 32'(disc));
        write_reg(CFG_PALETTE_SIZE, 32'(size));
    endtask

    // Samples half in the range, some near its ends or centre, some anywhere
    function automatic logic [31:0] pick_sample();
        longint lo, hi, pick;
        longint unsigned rnd;
        lo  = (lim_lo < lim_hi) ? lim_lo : lim_hi;
        hi  = (lim_lo < lim_hi) ? lim_hi : lim_lo;
        rnd = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 2))
                    0: pick = lim_lo;
                    1: pick = lim_hi;
                    default: pick = mid_pt;
                endcase
                return 32'(pick + $urandom_range(0, 8) - 4);
            end
            default: begin
                if (hi == lo) begin
                    return 32'(lo);
                end
                return 32'(lo + longint'(rnd % longint'(hi - lo + 1)));
            end
        endcase
    endfunction

    task automatic run_random(input int count);
        sender_calm = $urandom_range(0, 2) == 0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                sender_calm = !sender_calm;
            end
            if ($urandom_range(0, 7) == 0) begin
                send_entry(4'($urandom), $urandom);
            end else begin
                send_sample(pick_sample());
            end
        end
    endtask

    // ---- tests ----
    task automatic test_palette_load();
        send_entry(4'd0, 32'h0000_0000);
        send_entry(4'd15, 32'hFFFF_FFFF);
        for (int i = 1; i < 15; i++) begin
            send_entry(4'(i), $urandom);
        end
    endtask

    task automatic test_linear();
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'd0);
        send_sample(32'd32768);
        send_sample(32'd65536);
        run_random(150);
        set_mode(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 0, 0, 0, 5'd16);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        run_random(150);
    endtask

    task automatic test_centred();
        set_mode(-32'sd655360, 32'sd655360, 32'sd131072, 0, 1, 0, 5'd7);
        send_sample(32'sd131072);
        send_sample(32'sd131073);
        run_random(120);
        // centre on an end falls back to the midpoint
        set_mode(32'sd1000, 32'sd900000, 32'sd1000, 0, 1, 0, 5'd4);
        run_random(60);
        set_mode(32'sd1000, 32'sd900000, 32'sd900000, 0, 1, 1, 5'd9);
        run_random(60);
    endtask

    task automatic test_log();
        set_mode(32'h0000_0400, 32'h0100_0000, $urandom, 1, 1, 0, 5'd16);
        send_sample(32'd0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd1);
        send_sample(32'h7FFF_FFFF);
        run_random(130);
        // nonpositive limits act as one LSB
        set_mode(32'h8000_0000, 32'h0000_0000, 32'd5, 1, 0, 1, 5'd5);
        run_random(60);
    endtask

    task automatic test_discrete_sizes();
        set_mode(32'd0, 32'h0010_0000, 32'd0, 0, 0, 1, 5'd16);
        run_random(100);
        set_mode(32'd0, 32'h0010_0000, 32'd0, 0, 0, 1, 5'd0);
        run_random(40);
        set_mode(32'd0, 32'h0010_0000, 32'd0, 0, 0, 0, 5'd1);
        run_random(40);
        set_mode(32'd0, 32'h0010_0000, 32'd0, 0, 0, 0, 5'd31);
        run_random(80);
        set_mode(32'd0, 32'h0010_0000, 32'd0, 0, 0, 1, 5'd2);
        run_random(60);
    endtask

    task automatic test_degenerate_ranges();
        // empty range: zero divisor, opacity forced low
        set_mode(32'sd70000, 32'sd70000, 32'sd70000, 0, 0, 0, 5'd8);
        send_sample(32'sd70000);
        send_sample(32'sd70001);
        send_sample(32'sd69999);
        run_random(50);
        set_mode(32'sd70000, 32'sd70000, 32'sd0, 0, 1, 1, 5'd8);
        run_random(40);
        // reversed range
        set_mode(32'sd500000, -32'sd500000, 32'sd0, 0, 0, 0, 5'd12);
        run_random(80);
        set_mode(32'sd500000, -32'sd500000, 32'sd100, 0, 1, 0, 5'd12);
        run_random(60);
    endtask

    // Result side: random stall before each transfer, with calm stretches
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 63) == 0) begin
                sink_calm = !sink_calm;
            end
            stall = sink_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Scoreboard check of each result transfer
    always @(posedge aclk) begin
        vcm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (colour_q.size() == 0) begin
                report("unexpected colour", m_data, 0);
            end else begin
                want = colour_q.pop_front();
                n_checked++;
                if (m_data.red != want.red) report("red", m_data.red, want.red);
                if (m_data.green != want.green) report("green", m_data.green, want.green);
                if (m_data.blue != want.blue) report("blue", m_data.blue, want.blue);
                if (m_data.opacity != want.opacity) begin
                    report("opacity", m_data.opacity, want.opacity);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("timeout with %0d colours outstanding", colour_q.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            pal_model[i] = '0;
        end
        lim_lo = 0;
        lim_hi = 65536;
        mid_pt = 32768;
        log_on = 0;
        split_on = 0;
        band_on = 0;
        n_entries = 3;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_palette_load();
        test_linear();
        test_centred();
        test_log();
        test_discrete_sizes();
        test_degenerate_ranges();
        wait_drained();
        $display("covered linear, centred, log and discrete scaling over %0d samples",
                 n_samples);
        $display("%0d palette writes, %0d colours checked, %0d mismatches",
                 n_writes, n_checked, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/vcm_pkg.sv
sv/vcm_ram.sv
sv/value_to_colour_map.sv
bench/testbench.sv
